@@ rtl/imgrot_pkg.sv @@
package imgrot_pkg;

    // Geometry of the pixel store and the fixed-point format.
    localparam int MAX_SIDE   = 256;
    localparam int SIDE_BITS  = $clog2(MAX_SIDE);
    localparam int SIZE_BITS  = SIDE_BITS + 1;
    localparam int ADDR_BITS  = 2 * SIDE_BITS;
    localparam int PIXEL_BITS = 32;
    localparam int FRAC_BITS  = 14;

    // Field widths.
    localparam int COORD_BITS = 9;
    localparam int ANGLE_BITS = 16;
    localparam int SRC_BITS   = 9;
    localparam int DST_BITS   = 10;
    localparam int PIX_FIELD  = 32;

    // Datapath widths: centered coordinate, product, and position sum.
    localparam int DELTA_BITS = COORD_BITS + 2;
    localparam int PROD_BITS  = DELTA_BITS + ANGLE_BITS;
    localparam int SUM_BITS   = PROD_BITS + 2;

    // Stream and configuration port widths.
    localparam int IN_FIELD_BITS  = 2 * COORD_BITS + PIX_FIELD;
    localparam int IN_TDATA_W     = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W    = ((PIX_FIELD + 7) / 8) * 8;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = ANGLE_BITS;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_COS_ANGLE  = 3'd0,
        REG_SIN_ANGLE  = 3'd1,
        REG_SRC_WIDTH  = 3'd2,
        REG_SRC_HEIGHT = 3'd3,
        REG_DST_WIDTH  = 3'd4,
        REG_DST_HEIGHT = 3'd5
    } cfg_reg_t;

    // Commands carried in the input tuser.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Register reset values.
    localparam logic [ANGLE_BITS-1:0] COS_RESET = 16'sd16384;
    localparam logic [ANGLE_BITS-1:0] SIN_RESET = 16'sd0;
    localparam logic [SRC_BITS-1:0]   SRC_RESET = 9'd256;
    localparam logic [DST_BITS-1:0]   DST_RESET = 10'd256;

endpackage

@@ rtl/image_rotate_nearest.sv @@
// Channel  | Valid/ready        | tdata (low bit up)                  | tuser
// ---------+--------------------+-------------------------------------+-----------
// input    | s_tvalid/s_tready  | coord_x[8:0] coord_y[17:9]          | command
//          |                    | pixel_in[49:18], zero to 56 bits    |
// result   | m_tvalid/m_tready  | pixel_out[31:0]                     | inside_res
// config   | cfg_we             | cfg_addr index, cfg_wdata value     |
//
// One request is accepted per clock unless a result stalls. A sample result
// passes registered steps in order: center, multiply, sum, then the bounds test
// together with the single-port pixel store access. Loads use the same store slot
// and give no result. Reset clears the valid bits and the configuration; the store
// keeps its contents. When a result waits on m_tready, the whole pipeline holds.
module image_rotate_nearest (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [imgrot_pkg::IN_TDATA_W-1:0]  s_tdata,   // coord_x, coord_y, pixel_in
    input  logic                               s_tuser,   // command
    // Result stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [imgrot_pkg::OUT_TDATA_W-1:0] m_tdata,   // pixel_out
    output logic                               m_tuser,   // inside_res
    // Configuration writes.
    input  logic                               cfg_we,
    input  logic [imgrot_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [imgrot_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import imgrot_pkg::*;

    // Configuration registers.
    logic signed [ANGLE_BITS-1:0] cos_reg, sin_reg;
    logic [SRC_BITS-1:0]          src_w_reg, src_h_reg;
    logic [DST_BITS-1:0]          dst_w_reg, dst_h_reg;

    // Pipeline registers.
    logic                         s1_valid_reg, s1_sample_reg, s1_wok_reg;
    logic signed [DELTA_BITS-1:0] s1_dx_reg, s1_dy_reg;
    logic [ADDR_BITS-1:0]         s1_waddr_reg;
    logic [PIXEL_BITS-1:0]        s1_pixel_reg;

    logic                         s2_valid_reg, s2_sample_reg, s2_wok_reg;
    logic signed [PROD_BITS-1:0]  s2_xc_reg, s2_ys_reg, s2_xs_reg, s2_yc_reg;
    logic [ADDR_BITS-1:0]         s2_waddr_reg;
    logic [PIXEL_BITS-1:0]        s2_pixel_reg;

    logic                         s3_valid_reg, s3_sample_reg, s3_wok_reg;
    logic signed [SUM_BITS-1:0]   s3_px_reg, s3_py_reg;
    logic [ADDR_BITS-1:0]         s3_waddr_reg;
    logic [PIXEL_BITS-1:0]        s3_pixel_reg;

    logic                         s4_valid_reg, s4_sample_reg, s4_inside_reg;
    logic [PIXEL_BITS-1:0]        s4_rdata_reg;

    logic [PIXEL_BITS-1:0]        pix_mem [MAX_SIDE*MAX_SIDE];

    // Combinational signals.
    logic                         adv;
    logic [SIZE_BITS-1:0]         eff_w, eff_h;
    logic [COORD_BITS-1:0]        in_x, in_y;
    logic                         load_ok;
    logic [SUM_BITS-1:0]          bound_x, bound_y, half_x, half_y;
    logic                         inside_next;
    logic [SIDE_BITS-1:0]         ix, iy;
    logic [ADDR_BITS-1:0]         mem_addr;
    logic                         mem_we;

    // The pipeline moves whenever the result slot is empty or being taken.
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Configuration register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg   <= COS_RESET;
            sin_reg   <= SIN_RESET;
            src_w_reg <= SRC_RESET;
            src_h_reg <= SRC_RESET;
            dst_w_reg <= DST_RESET;
            dst_h_reg <= DST_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_COS_ANGLE:  cos_reg   <= cfg_wdata;
                REG_SIN_ANGLE:  sin_reg   <= cfg_wdata;
                REG_SRC_WIDTH:  src_w_reg <= cfg_wdata[SRC_BITS-1:0];
                REG_SRC_HEIGHT: src_h_reg <= cfg_wdata[SRC_BITS-1:0];
                REG_DST_WIDTH:  dst_w_reg <= cfg_wdata[DST_BITS-1:0];
                REG_DST_HEIGHT: dst_h_reg <= cfg_wdata[DST_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Source size saturated to the store side.
    assign eff_w = (src_w_reg > SRC_BITS'(MAX_SIDE)) ? SIZE_BITS'(MAX_SIDE)
                                                     : SIZE_BITS'(src_w_reg);
    assign eff_h = (src_h_reg > SRC_BITS'(MAX_SIDE)) ? SIZE_BITS'(MAX_SIDE)
                                                     : SIZE_BITS'(src_h_reg);

    // Field unpacking and load clipping.
    assign in_x    = s_tdata[COORD_BITS-1:0];
    assign in_y    = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign load_ok = (SIZE_BITS'(in_x) < eff_w) && (SIZE_BITS'(in_y) < eff_h);

    // Stage 1: center the destination coordinate.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_sample_reg <= (s_tuser == CMD_SAMPLE);
            s1_dx_reg     <= $signed(DELTA_BITS'(in_x))
                           - $signed(DELTA_BITS'(dst_w_reg[DST_BITS-1:1]));
            s1_dy_reg     <= $signed(DELTA_BITS'(in_y))
                           - $signed(DELTA_BITS'(dst_h_reg[DST_BITS-1:1]));
            s1_wok_reg    <= load_ok;
            s1_waddr_reg  <= {in_y[SIDE_BITS-1:0], in_x[SIDE_BITS-1:0]};
            s1_pixel_reg  <= s_tdata[2*COORD_BITS +: PIXEL_BITS];
        end
    end

    // Stage 2: the four rotation products.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_sample_reg <= s1_sample_reg;
            s2_xc_reg     <= s1_dx_reg * cos_reg;
            s2_ys_reg     <= s1_dy_reg * sin_reg;
            s2_xs_reg     <= s1_dx_reg * sin_reg;
            s2_yc_reg     <= s1_dy_reg * cos_reg;
            s2_wok_reg    <= s1_wok_reg;
            s2_waddr_reg  <= s1_waddr_reg;
            s2_pixel_reg  <= s1_pixel_reg;
        end
    end

    // Half source sizes moved to the fixed-point position.
    assign half_x = SUM_BITS'(eff_w[SIZE_BITS-1:1]) << FRAC_BITS;
    assign half_y = SUM_BITS'(eff_h[SIZE_BITS-1:1]) << FRAC_BITS;

    // Stage 3: source position sums.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_sample_reg <= s2_sample_reg;
            s3_px_reg     <= SUM_BITS'(s2_xc_reg) + SUM_BITS'(s2_ys_reg)
                           + $signed(half_x);
            s3_py_reg     <= SUM_BITS'(s2_yc_reg) - SUM_BITS'(s2_xs_reg)
                           + $signed(half_y);
            s3_wok_reg    <= s2_wok_reg;
            s3_waddr_reg  <= s2_waddr_reg;
            s3_pixel_reg  <= s2_pixel_reg;
        end
    end

    // Bounds test on the exact fixed-point position.
    assign bound_x     = SUM_BITS'(eff_w) << FRAC_BITS;
    assign bound_y     = SUM_BITS'(eff_h) << FRAC_BITS;
    assign inside_next = !s3_px_reg[SUM_BITS-1] && !s3_py_reg[SUM_BITS-1]
                      && ($unsigned(s3_px_reg) < bound_x)
                      && ($unsigned(s3_py_reg) < bound_y);
    assign ix = s3_px_reg[FRAC_BITS +: SIDE_BITS];
    assign iy = s3_py_reg[FRAC_BITS +: SIDE_BITS];

    // Loads and samples share one store port in the same stage, so order holds.
    assign mem_addr = s3_sample_reg ? {iy, ix} : s3_waddr_reg;
    assign mem_we   = adv && s3_valid_reg && !s3_sample_reg && s3_wok_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pix_mem[mem_addr] <= s3_pixel_reg;
        end
        if (adv) begin
            s4_rdata_reg <= pix_mem[mem_addr];
        end
    end

    // Stage 4: result slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (adv) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_sample_reg <= s3_sample_reg;
            s4_inside_reg <= inside_next;
        end
    end

    // Outputs: an outside position returns zero.
    assign m_tvalid = s4_valid_reg && s4_sample_reg;
    assign m_tuser  = s4_inside_reg;
    assign m_tdata  = s4_inside_reg ? OUT_TDATA_W'(s4_rdata_reg) : '0;

`ifndef ASSERT_OFF
    // A position that passes the bounds test addresses a pixel inside the source.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s3_valid_reg && s3_sample_reg && inside_next)
            |-> (SIZE_BITS'(ix) < eff_w) && (SIZE_BITS'(iy) < eff_h))
        else $error("inside position maps beyond the source size");

    // With no result waiting, the block always takes a new request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while the result slot is empty");

    // A stalled result keeps the pipeline frozen, so the store is not written.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !mem_we)
        else $error("store written during a result stall");
`endif

endmodule
